/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clock, held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/srtl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srtl_pkg
// Types, sizes and compare helpers for the sorted range table lookup core.
// ----------------------------------------------------------------------------
package srtl_pkg;

   localparam int ENTRIES = 256;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = IDX_W + 1;
   localparam int CAP_W   = 9;
   localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_SORT  = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef struct packed {
      logic        [7:0]  line;
      logic signed [31:0] low;
      logic signed [31:0] high;
      logic        [15:0] payload;
   } entry_type;

   // first field in the highest bits, last field in the lowest
   typedef struct packed {
      logic signed [31:0] query_post;
      logic signed [31:0] bound_b;
      logic signed [31:0] bound_a;
      logic        [15:0] entry_value;
      logic        [7:0]  line_id;
   } req_data_type;

   typedef struct packed {
      logic [5:0]  pad;
      logic        dropped;
      logic [15:0] found_value;
      logic        hit;
   } rsp_data_type;

   // true when entry a must sit after entry b
   function automatic logic goes_after(entry_type a, entry_type b);
      logic r;
      if (a.line != b.line) begin
         r = (a.line > b.line);
      end else begin
         r = (a.high > b.high);
      end
      return r;
   endfunction

   function automatic logic covers(entry_type e, logic [7:0] line,
                                   logic signed [31:0] post);
      return (e.line == line) && (post >= e.low) && (post <= e.high);
   endfunction

endpackage
`default_nettype wire

/* rtl/sorted_range_table_lookup_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_range_table_lookup_core
// Range table with append, stable insertion sort and bisection lookup.
// ----------------------------------------------------------------------------
// One request item is taken at a time and gives exactly one response item.
// Clear and add go through the execute and done states to the response
// register, and the next item can be taken once the core is back in idle.
// A query on an empty table goes straight to the done state; otherwise each
// bisection step is one read of the table memory followed by one compare, and
// the top and bottom checks cost one read each. Finalize is an insertion sort
// through the same memory port, and a reversed table is its worst case.
// There is no clearing pass after reset; the table holds no valid bits and
// only entries below the fill count are read. The response register frees
// the request side, so the next item may be accepted while a response still
// waits to be taken. Capacity writes are taken at any time and apply to the
// next add.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_range_table_lookup_core import srtl_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   // request: line_id, entry_value, bound_a, bound_b, query_post
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [$bits(req_data_type)-1:0] req_tdata,
   // request kind: mode
   input  logic [1:0]                    req_tuser,
   // response: hit, found_value, dropped, zero fill
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [$bits(rsp_data_type)-1:0] rsp_tdata,
   // capacity register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CAP_W-1:0]              csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SORT_RD,
      ST_SORT_KEY,
      ST_SORT_CMP,
      ST_SORT_PUT,
      ST_Q_TEST,
      ST_Q_MID,
      ST_Q_TOP,
      ST_Q_BOT,
      ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   req_data_type req_ff, req_in;
   mode_type     mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] bot_ff, bot_in;
   logic [IDX_W-1:0] top_ff, top_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   entry_type    key_ff, key_in;
   logic         hit_ff, hit_in;
   logic [15:0]  val_ff, val_in;
   logic         drop_ff, drop_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   // table memory
   entry_type    mem [ENTRIES];
   entry_type    rd_data_ff;
   logic         mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [IDX_W-1:0] mem_ra;
   entry_type    mem_wd;

   logic [LIM_W-1:0] limit;
   logic         full;
   logic         req_acc;
   logic [IDX_W-1:0] mid_calc;
   logic         more_keys;
   entry_type    new_entry;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign limit = (LIM_W'(cap_ff) > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES) : LIM_W'(cap_ff);
   assign full  = (LIM_W'(count_ff) >= limit);

   assign mid_calc  = bot_ff + ((top_ff - bot_ff) >> 1);
   assign more_keys = ((CNT_W'(i_ff) + CNT_W'(1)) < count_ff);

   always_comb begin
      new_entry.line    = req_ff.line_id;
      new_entry.payload = req_ff.entry_value;
      if (req_ff.bound_a <= req_ff.bound_b) begin
         new_entry.low  = req_ff.bound_a;
         new_entry.high = req_ff.bound_b;
      end else begin
         new_entry.low  = req_ff.bound_b;
         new_entry.high = req_ff.bound_a;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      bot_in       = bot_ff;
      top_in       = top_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      val_in       = val_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = j_ff;
      mem_wd       = key_ff;
      mem_ra       = i_ff;

      if (csr_valid && csr_ready) begin
         cap_in = csr_wdata;
      end

      // drop the response once taken; reloaded below if a new one is ready
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               req_in   = req_data_type'(req_tdata);
               mode_in  = mode_type'(req_tuser);
               hit_in   = 1'b0;
               val_in   = '0;
               drop_in  = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (mode_ff)
               MODE_CLEAR: begin
                  count_in = '0;
                  state_in = ST_DONE;
               end
               MODE_ADD: begin
                  if (full) begin
                     drop_in = 1'b1;
                  end else begin
                     mem_we   = 1'b1;
                     mem_wa   = count_ff[IDX_W-1:0];
                     mem_wd   = new_entry;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = ST_DONE;
               end
               MODE_SORT: begin
                  i_in     = IDX_W'(1);
                  state_in = (count_ff > CNT_W'(1)) ? ST_SORT_RD : ST_DONE;
               end
               MODE_QUERY: begin
                  bot_in   = '0;
                  top_in   = IDX_W'(count_ff - CNT_W'(1));
                  state_in = (count_ff == '0) ? ST_DONE : ST_Q_TEST;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SORT_RD: begin
            mem_ra   = i_ff;
            state_in = ST_SORT_KEY;
         end
         ST_SORT_KEY: begin
            key_in   = rd_data_ff;
            j_in     = i_ff;
            mem_ra   = i_ff - IDX_W'(1);
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            mem_we = 1'b1;
            mem_wa = j_ff;
            if (goes_after(rd_data_ff, key_ff)) begin
               // shift the larger entry up one place
               mem_wd = rd_data_ff;
               j_in   = j_ff - IDX_W'(1);
               if (j_ff > IDX_W'(1)) begin
                  mem_ra = j_ff - IDX_W'(2);
               end else begin
                  state_in = ST_SORT_PUT;
               end
            end else begin
               mem_wd = key_ff;
               if (more_keys) begin
                  i_in     = i_ff + IDX_W'(1);
                  mem_ra   = i_ff + IDX_W'(1);
                  state_in = ST_SORT_KEY;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SORT_PUT: begin
            mem_we = 1'b1;
            mem_wa = j_ff;
            mem_wd = key_ff;
            if (more_keys) begin
               i_in     = i_ff + IDX_W'(1);
               mem_ra   = i_ff + IDX_W'(1);
               state_in = ST_SORT_KEY;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_Q_TEST: begin
            if ((CNT_W'(bot_ff) + CNT_W'(1)) < CNT_W'(top_ff)) begin
               mem_ra   = mid_calc;
               mid_in   = mid_calc;
               state_in = ST_Q_MID;
            end else begin
               mem_ra   = top_ff;
               state_in = ST_Q_TOP;
            end
         end
         ST_Q_MID: begin
            state_in = ST_Q_TEST;
            if (rd_data_ff.line != req_ff.line_id) begin
               if (rd_data_ff.line > req_ff.line_id) begin
                  top_in = mid_ff;
               end else begin
                  bot_in = mid_ff;
               end
            end else if (req_ff.query_post > rd_data_ff.high) begin
               bot_in = mid_ff;
            end else if (req_ff.query_post < rd_data_ff.low) begin
               top_in = mid_ff;
            end else begin
               hit_in   = 1'b1;
               val_in   = rd_data_ff.payload;
               state_in = ST_DONE;
            end
         end
         ST_Q_TOP: begin
            if (covers(rd_data_ff, req_ff.line_id, req_ff.query_post)) begin
               hit_in   = 1'b1;
               val_in   = rd_data_ff.payload;
               state_in = ST_DONE;
            end else if (bot_ff == top_ff) begin
               state_in = ST_DONE;
            end else begin
               mem_ra   = bot_ff;
               state_in = ST_Q_BOT;
            end
         end
         ST_Q_BOT: begin
            if (covers(rd_data_ff, req_ff.line_id, req_ff.query_post)) begin
               hit_in = 1'b1;
               val_in = rd_data_ff.payload;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold the result until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pad         = '0;
               rsp_data_in.hit         = hit_ff;
               rsp_data_in.found_value = val_ff;
               rsp_data_in.dropped     = drop_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      mode_ff     <= mode_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      bot_ff      <= bot_in;
      top_ff      <= top_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      hit_ff      <= hit_in;
      val_ff      <= val_in;
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(ENTRIES), "entry count beyond table size")
   `ASSERT_IMPLIES(a_search_window, state_ff == ST_Q_TEST, (bot_ff <= top_ff) && (CNT_W'(top_ff) < count_ff), "search window outside filled table")
   `ASSERT_NEXT(a_add_counts, (state_ff == ST_EXEC) && (mode_ff == MODE_ADD) && !full, count_ff == $past(count_ff) + CNT_W'(1), "accepted add did not advance count")
   `ASSERT_IMPLIES(a_hit_xor_drop, rsp_valid_ff, !(rsp_data_ff.hit && rsp_data_ff.dropped), "response flags both hit and dropped")

endmodule
`default_nettype wire

/* tb/sorted_range_table_lookup_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_table_lookup_checker
// Watches the request, response and capacity channels of the range table
// core, keeps a private copy of the table and predicts every response item.
// Each accepted response is compared field by field with the oldest
// prediction; failures are counted and handed to the test top.
// ----------------------------------------------------------------------------
module sorted_range_table_lookup_checker import srtl_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // request: line_id, entry_value, bound_a, bound_b, query_post
   input  logic [$bits(req_data_type)-1:0] req_tdata,
   // request kind: mode
   input  logic [1:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // response: hit, found_value, dropped, zero fill
   input  logic [$bits(rsp_data_type)-1:0] rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [CAP_W-1:0]                csr_wdata,
   output int                              fail_count,
   output int                              pending_count
);

   localparam int NO_MATCH = -1;

   typedef struct {
      logic        hit;
      logic [15:0] found_value;
      logic        dropped;
   } reply_type;

   logic [7:0]  line_mem  [ENTRIES];
   int          low_mem   [ENTRIES];
   int          high_mem  [ENTRIES];
   logic [15:0] value_mem [ENTRIES];
   int          fill;
   int          capacity;
   reply_type   reply_q [$];

   // stable insertion sort on line id, then high post
   function automatic void sort_ranges();
      logic [7:0]  l;
      int          lo;
      int          hi;
      logic [15:0] v;
      int          j;
      for (int i = 1; i < fill; i++) begin
         l  = line_mem[i];
         lo = low_mem[i];
         hi = high_mem[i];
         v  = value_mem[i];
         j  = i;
         while (j > 0 && (line_mem[j-1] > l ||
                          (line_mem[j-1] == l && high_mem[j-1] > hi))) begin
            line_mem[j]  = line_mem[j-1];
            low_mem[j]   = low_mem[j-1];
            high_mem[j]  = high_mem[j-1];
            value_mem[j] = value_mem[j-1];
            j--;
         end
         line_mem[j]  = l;
         low_mem[j]   = lo;
         high_mem[j]  = hi;
         value_mem[j] = v;
      end
   endfunction

   function automatic bit range_holds(int k, logic [7:0] line, int post);
      return line_mem[k] == line && post >= low_mem[k] && post <= high_mem[k];
   endfunction

   // bisection, then the top and bottom checks
   function automatic int find_value(logic [7:0] line, int post);
      int bottom;
      int top;
      int mid;
      bit upper;
      if (fill == 0)
         return NO_MATCH;
      bottom = 0;
      top    = fill - 1;
      while (bottom < top - 1) begin
         mid = bottom + (top - bottom) / 2;
         if (line_mem[mid] != line)
            upper = line_mem[mid] > line;
         else if (post > high_mem[mid])
            upper = 1'b0;
         else if (post < low_mem[mid])
            upper = 1'b1;
         else
            return value_mem[mid];
         if (upper)
            top = mid;
         else
            bottom = mid;
      end
      if (range_holds(top, line, post))
         return value_mem[top];
      if (bottom != top && range_holds(bottom, line, post))
         return value_mem[bottom];
      return NO_MATCH;
   endfunction

   function automatic reply_type step_table(mode_type mode, req_data_type d);
      reply_type r;
      int        found;
      int        a;
      int        b;
      r = '{hit: 1'b0, found_value: 16'd0, dropped: 1'b0};
      case (mode)
         MODE_CLEAR: fill = 0;
         MODE_ADD: begin
            if (fill >= ((capacity > ENTRIES) ? ENTRIES : capacity)) begin
               r.dropped = 1'b1;
            end else begin
               a               = d.bound_a;
               b               = d.bound_b;
               line_mem[fill]  = d.line_id;
               value_mem[fill] = d.entry_value;
               low_mem[fill]   = (a <= b) ? a : b;
               high_mem[fill]  = (a <= b) ? b : a;
               fill++;
            end
         end
         MODE_SORT: if (fill > 1) sort_ranges();
         MODE_QUERY: begin
            found = find_value(d.line_id, d.query_post);
            if (found != NO_MATCH) begin
               r.hit         = 1'b1;
               r.found_value = 16'(found);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_type    want;
      rsp_data_type got;
      if (reset) begin
         fill       = 0;
         capacity   = CAP_RESET;
         fail_count = 0;
         reply_q.delete();
         pending_count <= 0;
      end else begin
         if (csr_valid && csr_ready)
            capacity = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (reply_q.size() == 0) begin
               $error("response item with no request outstanding");
               fail_count++;
            end else begin
               want = reply_q.pop_front();
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, got.hit);
                  fail_count++;
               end
               if (got.found_value !== want.found_value) begin
                  $error("found_value: expected %0d, got %0d",
                         want.found_value, got.found_value);
                  fail_count++;
               end
               if (got.dropped !== want.dropped) begin
                  $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            reply_q.push_back(step_table(mode_type'(req_tuser), req_data_type'(req_tdata)));
         pending_count <= reply_q.size();
      end
   end

endmodule

/* tb/sorted_range_table_lookup_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_range_table_lookup_core_test
// Stimulus for the range table core: a directed pass over the corner cases,
// then random sessions of clear, add, finalize and query with random stalls
// on both sides, one full reversed table and a long response hold-off.
// ----------------------------------------------------------------------------
module sorted_range_table_lookup_core_test;
   import srtl_pkg::*;

   localparam int ITEM_TARGET = 950;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 64;
   localparam int POST_MIN    = int'(32'h8000_0000);
   localparam int POST_MAX    = int'(32'h7FFF_FFFF);

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [$bits(req_data_type)-1:0] req_tdata  = '0;
   logic [1:0]                      req_tuser  = MODE_CLEAR;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [$bits(rsp_data_type)-1:0] rsp_tdata;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [CAP_W-1:0]                csr_wdata  = CAP_RESET;

   int fail_count;
   int pending_count;
   int items_sent       = 0;
   int cycle_count      = 0;
   bit idle_enable      = 1'b1;
   bit quiet_session    = 1'b0;
   bit long_hold_wanted = 1'b0;
   bit long_hold_done   = 1'b0;

   // ranges added in the current session, for aiming queries
   logic [7:0] known_line [$];
   int         known_low  [$];
   int         known_high [$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sorted_range_table_lookup_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   sorted_range_table_lookup_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold_wanted && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   task automatic send_item(input mode_type mode, input logic [7:0] line,
                            input logic [15:0] value, input int a, input int b,
                            input int post);
      req_data_type d;
      if (idle_enable && !quiet_session && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      d.line_id     = line;
      d.entry_value = value;
      d.bound_a     = a;
      d.bound_b     = b;
      d.query_post  = post;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // drop valid and hold until every response item has been taken
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic int rand_post();
      case ($urandom_range(0, 7))
         0:       return POST_MIN;
         1:       return POST_MAX;
         2, 3:    return int'($urandom);
         default: return int'($urandom_range(0, 4000)) - 2000;
      endcase
   endfunction

   task automatic add_range(input logic [7:0] line, input int a, input int b);
      known_line.push_back(line);
      known_low.push_back((a <= b) ? a : b);
      known_high.push_back((a <= b) ? b : a);
      send_item(MODE_ADD, line, 16'($urandom), a, b, $urandom);
   endtask

   // aim mostly at known ranges: inside, on either limit, or just outside
   task automatic query_known();
      int         k;
      int         post;
      longint     span;
      logic [7:0] line;
      if (known_line.size() == 0 || $urandom_range(0, 4) == 0) begin
         line = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
         post = rand_post();
      end else begin
         k    = $urandom_range(0, known_line.size() - 1);
         line = known_line[k];
         case ($urandom_range(0, 5))
            0: post = known_low[k];
            1: post = known_high[k];
            2: post = known_low[k] - 1;
            3: post = known_high[k] + 1;
            default: begin
               span = longint'(known_high[k]) - longint'(known_low[k]) + 1;
               post = int'(longint'(known_low[k]) + longint'($urandom) % span);
            end
         endcase
      end
      send_item(MODE_QUERY, line, 16'($urandom), $urandom, $urandom, post);
   endtask

   task automatic table_session(input int n_adds, input int n_queries, input bit reversed);
      logic [7:0] line;
      int         a;
      int         b;
      int         t;
      bit         narrow;
      narrow        = $urandom_range(0, 2) != 0;
      quiet_session = $urandom_range(0, 3) == 0;
      known_line.delete();
      known_low.delete();
      known_high.delete();
      send_item(MODE_CLEAR, 8'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
      for (int i = 0; i < n_adds; i++) begin
         if (reversed) begin
            // line and high post fall as the fill goes on: worst case for the sort
            line = 8'(255 - i / 2);
            a    = -1000 * i;
            b    = a + 1 + $urandom_range(0, 400);
         end else if (known_line.size() != 0 && $urandom_range(0, 3) == 0) begin
            // start where the last range ended, so the two share a limit
            line = known_line[$];
            a    = known_high[$];
            b    = a + $urandom_range(0, 300);
         end else begin
            line = narrow ? 8'($urandom_range(0, 7)) : 8'($urandom);
            if ($urandom_range(0, 3) == 0) begin
               a = $urandom;
               b = $urandom;
            end else begin
               a = rand_post();
               b = a + $urandom_range(0, 300);
            end
         end
         if ($urandom_range(0, 1)) begin
            t = a;
            a = b;
            b = t;
         end
         if (!reversed && $urandom_range(0, 14) == 0)
            send_item(mode_type'($urandom_range(0, 1) ? MODE_QUERY : MODE_SORT),
                      8'($urandom), 16'($urandom), $urandom, $urandom, rand_post());
         add_range(line, a, b);
      end
      if ($urandom_range(0, 3) == 0)
         repeat (3) query_known();
      send_item(MODE_SORT, 8'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
      if (reversed)
         long_hold_wanted = 1'b1;
      repeat (n_queries) query_known();
      case ($urandom_range(0, 7))
         0: begin
            add_range(8'($urandom_range(0, 7)), rand_post(), rand_post());
            repeat (3) query_known();
         end
         1: begin
            send_item(MODE_CLEAR, 8'($urandom), 16'($urandom), $urandom, $urandom,
                      $urandom);
            known_line.delete();
            known_low.delete();
            known_high.delete();
            query_known();
         end
         default: ;
      endcase
   endtask

   initial begin
      int session;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty table straight after reset
      send_item(MODE_QUERY, 8'd0, 16'd0, 0, 0, 0);
      send_item(MODE_QUERY, 8'hFF, 16'hFFFF, POST_MAX, POST_MIN, POST_MIN);
      settle();

      // capacity of three: the fourth add is refused
      write_capacity(9'd3);
      send_item(MODE_ADD, 8'hFF, 16'hFFFF, POST_MAX, POST_MIN, 0);
      send_item(MODE_ADD, 8'd0, 16'd0, -5, -5, 0);
      send_item(MODE_ADD, 8'd7, 16'h1234, 100, -100, 0);
      send_item(MODE_ADD, 8'd9, 16'd1, 0, 0, 0);
      send_item(MODE_QUERY, 8'd7, 16'd0, 0, 0, 0);
      send_item(MODE_SORT, 8'd0, 16'd0, 0, 0, 0);
      send_item(MODE_QUERY, 8'hFF, 16'd0, 0, 0, POST_MIN);
      send_item(MODE_QUERY, 8'hFF, 16'd0, 0, 0, POST_MAX);
      send_item(MODE_QUERY, 8'd0, 16'd0, 0, 0, -5);
      send_item(MODE_QUERY, 8'd0, 16'd0, 0, 0, -4);
      send_item(MODE_QUERY, 8'd7, 16'd0, 0, 0, 101);
      settle();

      // capacity below the fill count: entries stay, adds are refused
      write_capacity(9'd0);
      send_item(MODE_ADD, 8'd1, 16'h5555, 1, 2, 0);
      send_item(MODE_SORT, 8'd0, 16'd0, 0, 0, 0);
      send_item(MODE_QUERY, 8'd7, 16'd0, 0, 0, -100);
      send_item(MODE_CLEAR, 8'd0, 16'd0, 0, 0, 0);
      send_item(MODE_QUERY, 8'd7, 16'd0, 0, 0, 0);
      settle();

      // capacity above the table size saturates; a post on a shared limit
      write_capacity(9'h1FF);
      send_item(MODE_ADD, 8'd3, 16'd10, 0, 50, 0);
      send_item(MODE_ADD, 8'd3, 16'd20, 90, 50, 0);
      send_item(MODE_ADD, 8'd3, 16'd30, -10, -1, 0);
      send_item(MODE_SORT, 8'd0, 16'd0, 0, 0, 0);
      send_item(MODE_QUERY, 8'd3, 16'd0, 0, 0, 50);
      send_item(MODE_QUERY, 8'd3, 16'd0, 0, 0, 90);

      session = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent > ITEM_TARGET * 4 / 5)
            idle_enable = 1'b0;
         settle();
         if (session == 3) begin
            // overfill a full-size table in reverse order, then hold responses off
            write_capacity(9'd256);
            table_session(ENTRIES + 4, 30, 1'b1);
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               case ($urandom_range(0, 5))
                  0:       write_capacity(9'd0);
                  1:       write_capacity(9'h1FF);
                  2:       write_capacity(9'($urandom_range(1, 12)));
                  3:       write_capacity(9'($urandom));
                  default: write_capacity(9'd256);
               endcase
            end
            table_session($urandom_range(1, 20), $urandom_range(4, 20), 1'b0);
         end
         session++;
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
